@@ rtl/afm_pkg.sv @@
// shared types, constants and transition function of the allocation trace monitor
package afm_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MODE_W          = 2;
    localparam int KEY_W           = 64;
    localparam int STATE_W         = 2;
    localparam int TOTAL_W         = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_END   = 2'd2,
        MODE_OTHER = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_fsm;

    localparam logic [STATE_W-1:0] ST_NEW   = 2'd0;
    localparam logic [STATE_W-1:0] ST_ALLOC = 2'd1;
    localparam logic [STATE_W-1:0] ST_FREED = 2'd2;
    localparam logic [STATE_W-1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic               violation;
        logic               wrong_event;
        logic               table_full;
        logic               trace_end;
        logic [TOTAL_W-1:0] violation_total;
        logic [STATE_W-1:0] entry_state;
    } t_result;

    typedef struct packed {
        logic [STATE_W-1:0] next;
        logic               viol;
        logic               wrong;
    } t_step;

    function automatic t_step next_step(input t_mode mode, input logic [STATE_W-1:0] cur);
        t_step s;
        s.next  = cur;
        s.viol  = 1'b0;
        s.wrong = 1'b0;
        unique case (mode)
            MODE_ALLOC: begin
                s.next = (cur == ST_NEW) ? ST_ALLOC : ST_BAD;
                s.viol = (cur != ST_NEW);
            end
            MODE_FREE: begin
                s.next = (cur == ST_NEW) ? ST_BAD : ST_FREED;
            end
            default: begin
                s.wrong = 1'b1;
            end
        endcase
        return s;
    endfunction

endpackage

@@ rtl/afm_if.sv @@
// valid/ready channel interfaces for trace events and monitor results
interface afm_in_if;
    import afm_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  address;

    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

interface afm_out_if;
    import afm_pkg::*;

    logic               valid;
    logic               ready;
    logic               violation;
    logic               wrong_event;
    logic               table_full;
    logic               trace_end;
    logic [TOTAL_W-1:0] violation_total;
    logic [STATE_W-1:0] entry_state;

    modport source (output valid, output violation, output wrong_event, output table_full,
                    output trace_end, output violation_total, output entry_state,
                    input ready);
    modport sink   (input valid, input violation, input wrong_event, input table_full,
                    input trace_end, input violation_total, input entry_state,
                    output ready);
endinterface

@@ rtl/afm_ram.sv @@
// generic simple dual-port ram with registered read
module afm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/afm_ctrl.sv @@
// lookup sequencer: key scan, state update, violation count and result register
module afm_ctrl #(
    parameter int TABLE_DEPTH = afm_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    afm_in_if.sink                      i_in,
    afm_out_if.source                   o_out,
    output logic                        o_key_we,
    output logic                        o_st_we,
    output logic [ADDR_W-1:0]           o_waddr,
    output logic [ADDR_W-1:0]           o_raddr,
    output logic [afm_pkg::KEY_W-1:0]   o_key_wdata,
    output logic [afm_pkg::STATE_W-1:0] o_st_wdata,
    input  logic [afm_pkg::KEY_W-1:0]   i_key_rdata,
    input  logic [afm_pkg::STATE_W-1:0] i_st_rdata
);
    import afm_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_fsm               r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CNT_W-1:0]   r_issue, n_issue;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_idx, n_pend_idx;
    t_result            r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic               hit;
    logic               miss;
    logic               room;
    logic [STATE_W-1:0] cur;
    t_step              step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // read data of the previous cycle belongs to r_pend_idx
    assign hit  = r_pend && (i_key_rdata == r_key);
    assign miss = !r_pend && (r_issue >= r_fill);
    assign room = r_fill < CNT_W'(TABLE_DEPTH);
    assign cur  = hit ? i_st_rdata : ST_NEW;
    assign step = next_step(r_mode, cur);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_key       = r_key;
        n_fill      = r_fill;
        n_total     = r_total;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_key_we    = 1'b0;
        o_st_we     = 1'b0;
        o_waddr     = r_pend_idx;
        o_raddr     = r_issue[ADDR_W-1:0];
        o_key_wdata = r_key;
        o_st_wdata  = step.next;
        i_in.ready  = (r_state == S_IDLE);

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode  = t_mode'(i_in.mode);
                    n_key   = i_in.address;
                    n_issue = '0;
                    n_pend  = 1'b0;
                    if (t_mode'(i_in.mode) == MODE_END) begin
                        n_res                 = '0;
                        n_res.trace_end       = 1'b1;
                        n_res.violation_total = r_total;
                        n_fill                = '0;
                        n_total               = '0;
                        n_state               = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit || miss) begin
                    if (hit) begin
                        o_st_we = 1'b1;
                    end else if (room) begin
                        // new address goes to the next free entry
                        o_key_we = 1'b1;
                        o_st_we  = 1'b1;
                        o_waddr  = r_fill[ADDR_W-1:0];
                        n_fill   = r_fill + CNT_W'(1);
                    end
                    if (step.viol && (r_total != '1)) begin
                        n_total = r_total + TOTAL_W'(1);
                    end
                    n_res.violation       = step.viol;
                    n_res.wrong_event     = step.wrong;
                    n_res.table_full      = miss && !room;
                    n_res.trace_end       = 1'b0;
                    n_res.violation_total = n_total;
                    n_res.entry_state     = step.next;
                    n_pend                = 1'b0;
                    n_state               = S_DONE;
                end else if (r_issue < r_fill) begin
                    n_issue    = r_issue + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[ADDR_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.violation       = r_out.violation;
    assign o_out.wrong_event     = r_out.wrong_event;
    assign o_out.table_full      = r_out.table_full;
    assign o_out.trace_end       = r_out.trace_end;
    assign o_out.violation_total = r_out.violation_total;
    assign o_out.entry_state     = r_out.entry_state;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_key_we || o_st_we) |-> (r_state == S_SCAN))
        else $error("table write outside scan");

    a_key_write_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_we |-> (o_st_we && !r_pend && (o_waddr == r_fill[ADDR_W-1:0])))
        else $error("key written without a miss at fill position");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in.valid && t_mode'(i_in.mode) == MODE_END)
        |=> (r_fill == '0 && r_total == '0 && r_state == S_DONE))
        else $error("end of trace did not clear table and count");
endmodule

@@ rtl/alloc_free_typestate_monitor_top.sv @@
// an event is accepted in idle, then the scan reads the held entries in order until a hit
// or, on a miss, past the last one; the done state passes the result to the output register
// events are taken only in idle; the scan is bound by the single read port of the key ram
// end of trace goes straight to done and empties the table by zeroing the fill count
// reset: synchronous active low, clears fill count, violation count and valid flags;
// table memories are not cleared, entries at or beyond the fill count are never read
module alloc_free_typestate_monitor_top #(
    parameter int TABLE_DEPTH = afm_pkg::TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afm_in_if.sink    i_in,
    afm_out_if.source o_out
);
    import afm_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic               key_we;
    logic               st_we;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [KEY_W-1:0]   key_wdata;
    logic [STATE_W-1:0] st_wdata;
    logic [KEY_W-1:0]   key_rdata;
    logic [STATE_W-1:0] st_rdata;

    afm_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_key_we    (key_we),
        .o_st_we     (st_we),
        .o_waddr     (waddr),
        .o_raddr     (raddr),
        .o_key_wdata (key_wdata),
        .o_st_wdata  (st_wdata),
        .i_key_rdata (key_rdata),
        .i_st_rdata  (st_rdata)
    );

    afm_ram #(
        .WIDTH  (KEY_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    afm_ram #(
        .WIDTH  (STATE_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (waddr),
        .i_wdata (st_wdata),
        .i_raddr (raddr),
        .o_rdata (st_rdata)
    );
endmodule

@@ sim/afm_result_checker.sv @@
// result checker: predicts each monitor result from accepted events and compares it field by field
module afm_result_checker #(
    parameter int DEPTH = afm_pkg::TABLE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    afm_in_if    i_ev,
    afm_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_viol_seen,
    output int   o_full_seen,
    output int   o_ends_seen
);
    import afm_pkg::*;

    logic [KEY_W-1:0]   tracked_key   [DEPTH];
    logic [STATE_W-1:0] tracked_state [DEPTH];
    int                 tracked_count = 0;
    logic [TOTAL_W-1:0] viol_total    = '0;
    t_result            awaited_results [$];

    int fails      = 0;
    int pending_n  = 0;
    int viol_seen  = 0;
    int full_seen  = 0;
    int ends_seen  = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_n;
    assign o_viol_seen  = viol_seen;
    assign o_full_seen  = full_seen;
    assign o_ends_seen  = ends_seen;

    // advance the tracked table by one event and return the result it should give
    function automatic t_result track_event(input t_mode kind, input logic [KEY_W-1:0] addr);
        t_result            r;
        int                 slot;
        int                 k;
        logic [STATE_W-1:0] cur;
        logic [STATE_W-1:0] nxt;
        r = '0;
        if (kind == MODE_END) begin
            r.trace_end       = 1'b1;
            r.violation_total = viol_total;
            tracked_count     = 0;
            viol_total        = '0;
            return r;
        end
        slot = -1;
        for (k = 0; k < tracked_count; k++) begin
            if (slot < 0 && tracked_key[k] == addr) slot = k;
        end
        cur = ST_NEW;
        if (slot >= 0) begin
            cur = tracked_state[slot];
        end else if (tracked_count < DEPTH) begin
            slot               = tracked_count;
            tracked_key[slot]  = addr;
            tracked_count      = tracked_count + 1;
        end else begin
            // new key with no room: judged from a fresh entry, nothing stored
            r.table_full = 1'b1;
        end
        case (kind)
            MODE_ALLOC: begin
                nxt         = (cur == ST_NEW) ? ST_ALLOC : ST_BAD;
                r.violation = (cur != ST_NEW);
            end
            MODE_FREE: begin
                nxt = (cur == ST_NEW) ? ST_BAD : ST_FREED;
            end
            default: begin
                nxt           = cur;
                r.wrong_event = 1'b1;
            end
        endcase
        if (slot >= 0) tracked_state[slot] = nxt;
        if (r.violation && viol_total != '1) viol_total = viol_total + TOTAL_W'(1);
        r.violation_total = viol_total;
        r.entry_state     = nxt;
        return r;
    endfunction

    function automatic void flag_field(input string field, input longint unsigned want_v,
                                       input longint unsigned got_v);
        fails = fails + 1;
        if (fails <= 30)
            $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            tracked_count = 0;
            viol_total    = '0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.violation       = i_res.violation;
                got.wrong_event     = i_res.wrong_event;
                got.table_full      = i_res.table_full;
                got.trace_end       = i_res.trace_end;
                got.violation_total = i_res.violation_total;
                got.entry_state     = i_res.entry_state;
                if (awaited_results.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 30)
                        $display("%0t: result beat expected none got %h", $time, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.violation !== want.violation)
                        flag_field("violation", 64'(want.violation), 64'(got.violation));
                    if (got.wrong_event !== want.wrong_event)
                        flag_field("wrong_event", 64'(want.wrong_event),
                                   64'(got.wrong_event));
                    if (got.table_full !== want.table_full)
                        flag_field("table_full", 64'(want.table_full), 64'(got.table_full));
                    if (got.trace_end !== want.trace_end)
                        flag_field("trace_end", 64'(want.trace_end), 64'(got.trace_end));
                    if (got.violation_total !== want.violation_total)
                        flag_field("violation_total", 64'(want.violation_total),
                                   64'(got.violation_total));
                    if (got.entry_state !== want.entry_state)
                        flag_field("entry_state", 64'(want.entry_state),
                                   64'(got.entry_state));
                    if (want.violation)  viol_seen = viol_seen + 1;
                    if (want.table_full) full_seen = full_seen + 1;
                    if (want.trace_end)  ends_seen = ends_seen + 1;
                end
            end
            if (i_ev.valid && i_ev.ready)
                awaited_results.push_back(track_event(t_mode'(i_ev.mode), i_ev.address));
            pending_n = awaited_results.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// testbench top: drives trace events and result stalls around the monitor and gives the verdict
module tb;
    import afm_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOT_N       = 16;

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   fails;
    int   pending;
    int   viol_seen;
    int   full_seen;
    int   ends_seen;
    int   sent = 0;

    logic [KEY_W-1:0] fill_keys [DEPTH];
    logic [KEY_W-1:0] hot_keys  [HOT_N];

    afm_in_if  ev_ch ();
    afm_out_if res_ch ();

    alloc_free_typestate_monitor_top #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_ch),
        .o_out   (res_ch)
    );

    afm_result_checker #(
        .DEPTH (DEPTH)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ev         (ev_ch),
        .i_res        (res_ch),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_viol_seen  (viol_seen),
        .o_full_seen  (full_seen),
        .o_ends_seen  (ends_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [KEY_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic t_mode rand_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42) return MODE_ALLOC;
        if (r < 84) return MODE_FREE;
        return MODE_OTHER;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_event(input t_mode kind, input logic [KEY_W-1:0] addr);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            ev_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ev_ch.valid   = 1'b1;
        ev_ch.mode    = kind;
        ev_ch.address = addr;
        @(posedge i_clk);
        while (!ev_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent = sent + 1;
    endtask

    // result side back-pressure
    initial begin
        int hold;
        hold         = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                res_ch.ready = 1'b0;
                hold         = hold - 1;
            end else begin
                res_ch.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) hold = idle_len();
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0] addr;
        int               n;
        int               r;
        i_rst_n       = 1'b0;
        quiet         = 1'b0;
        ev_ch.valid   = 1'b0;
        ev_ch.mode    = MODE_ALLOC;
        ev_ch.address = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: each transition, wrong events, extreme keys, trace ends
        send_event(MODE_ALLOC, '0);
        send_event(MODE_ALLOC, '0);
        send_event(MODE_FREE,  '0);
        send_event(MODE_ALLOC, '0);
        send_event(MODE_FREE,  '1);
        send_event(MODE_FREE,  '1);
        send_event(MODE_OTHER, '1);
        send_event(MODE_OTHER, 64'h5555_5555_5555_5555);
        send_event(MODE_ALLOC, 64'h5555_5555_5555_5555);
        send_event(MODE_FREE,  64'h5555_5555_5555_5555);
        send_event(MODE_FREE,  64'h5555_5555_5555_5555);
        send_event(MODE_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA);
        send_event(MODE_OTHER, 64'hAAAA_AAAA_AAAA_AAAA);
        send_event(MODE_FREE,  64'hAAAA_AAAA_AAAA_AAAA);
        send_event(MODE_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA);
        send_event(MODE_OTHER, '0);
        send_event(MODE_END,   rand_addr());
        send_event(MODE_ALLOC, '0);
        send_event(MODE_END,   '1);
        send_event(MODE_END,   '0);
        send_event(MODE_FREE,  64'h8000_0000_0000_0000);
        send_event(MODE_ALLOC, 64'h8000_0000_0000_0000);
        send_event(MODE_OTHER, 64'h0000_0000_0000_0001);
        send_event(MODE_END,   rand_addr());

        // fill every entry, then push new keys at a full table and revisit old ones
        for (n = 0; n < DEPTH; n++) begin
            fill_keys[n] = {$urandom, 24'($urandom), 8'(n)};
            send_event(rand_kind(), fill_keys[n]);
        end
        for (n = 0; n < 12; n++) send_event(rand_kind(), rand_addr());
        send_event(rand_kind(), fill_keys[DEPTH-1]);
        send_event(rand_kind(), fill_keys[0]);
        for (n = 0; n < 30; n++)
            send_event(rand_kind(), fill_keys[$urandom_range(0, DEPTH-1)]);
        send_event(MODE_END, rand_addr());

        // random traces over a small set of live keys, with fresh keys and ends mixed in
        for (n = 0; n < HOT_N; n++) hot_keys[n] = rand_addr();
        for (n = 0; n < 800; n++) begin
            if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_event(MODE_END, rand_addr());
                hot_keys[$urandom_range(0, HOT_N-1)] = rand_addr();
            end else begin
                addr = (r < 12) ? rand_addr() : hot_keys[$urandom_range(0, HOT_N-1)];
                send_event(rand_kind(), addr);
            end
        end
        ev_ch.valid = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("%0d events sent: %0d violations, %0d inserts refused, %0d trace ends",
                 sent, viol_seen, full_seen, ends_seen);
        $display("covered every transition, a table filled past capacity, stalls on both sides");
        if (fails == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ alloc_free_typestate_monitor_top.f @@
rtl/afm_pkg.sv
rtl/afm_if.sv
rtl/afm_ram.sv
rtl/afm_ctrl.sv
rtl/alloc_free_typestate_monitor_top.sv
sim/afm_result_checker.sv
sim/tb.sv
